@@ hw/rtl/blr_pkg.sv @@
// Shared types, constants and codes of the bilinear RGBA8 resampler.
package blr_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SRC_W    = 9;
  localparam int unsigned STEP_W   = 24;
  localparam int unsigned DEST_W   = 10;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned NUM_CHAN = PIXEL_W / CHAN_W;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Image store depth and fixed-point format.
  localparam int unsigned MAX_SOURCE_PIXELS = 65536;
  localparam int unsigned MAX_DEST_DIM      = 1024;
  localparam int unsigned FRACTION_BITS     = 16;

  // Default queue depths.
  localparam int unsigned CMD_QUEUE_DEPTH = 4;
  localparam int unsigned RES_QUEUE_DEPTH = 4;

  // Register reset values.
  localparam logic [SRC_W-1:0]  SOURCE_WIDTH_RST = SRC_W'(256);
  localparam logic [STEP_W-1:0] STEP_RST         = STEP_W'(65536);

  // Item opcodes.
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH = 2'd0,
    CFG_STEP_X       = 2'd1,
    CFG_STEP_Y       = 2'd2
  } cfg_idx_e;

  // Configuration register set.
  typedef struct packed {
    logic [SRC_W-1:0]  source_width;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
  } cfg_t;

  // Command handed from the front end to the back end.
  typedef struct packed {
    logic                     is_sample;
    logic [ADDR_W-1:0]        addr;
    logic [ADDR_W-1:0]        addr_c;
    logic [PIXEL_W-1:0]       pixel;
    logic [FRACTION_BITS-1:0] frac_x;
    logic [FRACTION_BITS-1:0] frac_y;
  } cmd_t;

endpackage

@@ hw/rtl/blr_queue.sv @@
// Small first-in first-out queue with a registered storage array.
module blr_queue #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [IW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [IW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  // Handshake and occupancy.
  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and count updates with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/blr_front.sv @@
// Front end: accepts items, scales sample coordinates and forms store addresses.
module blr_front import blr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [ADDR_W-1:0]   load_address_i,
  input  logic [PIXEL_W-1:0]  load_pixel_i,
  input  logic [DEST_W-1:0]   dest_column_i,
  input  logic [DEST_W-1:0]   dest_row_i,
  output logic                cmd_push_o,
  output cmd_t                cmd_o,
  input  logic                cmd_ready_i
);

  // Width of a scaled coordinate in fixed point.
  localparam int unsigned PW = STEP_W + DEST_W;
  localparam int unsigned MW = ADDR_W + SRC_W;

  logic               s1_vld_q, s1_vld_d;
  logic               s1_en, accept;
  logic               s1_sample_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic [PIXEL_W-1:0] s1_pixel_q;
  logic [PW-1:0]      s1_px_q, s1_py_q;
  logic [PW-1:0]      xi_full, yi_full;
  logic [MW-1:0]      row_prod;
  logic [ADDR_W-1:0]  row_base, xi, sw_ext;

  // The stage takes a new item when empty or when its item moves on.
  assign s1_en      = ~s1_vld_q | cmd_ready_i;
  assign in_ready_o = s1_en;
  assign accept     = in_valid_i & s1_en;
  assign s1_vld_d   = s1_en ? in_valid_i : s1_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  // Capture the item and scale the destination position by the steps.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= (opcode_i == OP_SAMPLE);
      s1_addr_q   <= load_address_i;
      s1_pixel_q  <= load_pixel_i;
      s1_px_q     <= PW'(cfg_i.step_x) * PW'(dest_column_i);
      s1_py_q     <= PW'(cfg_i.step_y) * PW'(dest_row_i);
    end
  end

  // Integer parts select the top-left neighbor; addresses wrap at the store size.
  always_comb begin
    xi_full  = s1_px_q >> FRACTION_BITS;
    yi_full  = s1_py_q >> FRACTION_BITS;
    xi       = xi_full[ADDR_W-1:0];
    sw_ext   = ADDR_W'(cfg_i.source_width);
    row_prod = MW'(yi_full[ADDR_W-1:0]) * MW'(cfg_i.source_width);
    row_base = row_prod[ADDR_W-1:0];
  end

  // Build the command for the back end.
  always_comb begin
    cmd_o.is_sample = s1_sample_q;
    cmd_o.pixel     = s1_pixel_q;
    cmd_o.frac_x    = s1_px_q[FRACTION_BITS-1:0];
    cmd_o.frac_y    = s1_py_q[FRACTION_BITS-1:0];
    if (s1_sample_q) begin
      cmd_o.addr = row_base + xi;
    end else begin
      cmd_o.addr = s1_addr_q;
    end
    cmd_o.addr_c = row_base + xi + sw_ext;
  end

  assign cmd_push_o = s1_vld_q;

endmodule

@@ hw/rtl/blr_back.sv @@
// Back end: image store, neighbor fetch sequencer and bilinear blend pipeline.
module blr_back import blr_pkg::*; #(
  parameter int unsigned RES_DEPTH = RES_QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_pop_i,
  output logic               res_push_o,
  output logic [PIXEL_W-1:0] res_pixel_o
);

  localparam int unsigned CW = $clog2(RES_DEPTH + 1);
  localparam int unsigned WW = FRACTION_BITS + 1;
  localparam int unsigned HW = CHAN_W + FRACTION_BITS;
  localparam int unsigned VW = CHAN_W + 2 * FRACTION_BITS;
  localparam logic [WW-1:0] ONE = WW'(1) << FRACTION_BITS;

  // Fetch sequencer states.
  typedef enum logic [1:0] {
    ST_PAIR_AB = 2'b01,
    ST_PAIR_CD = 2'b10
  } fetch_state_e;

  fetch_state_e state_q, state_d;

  logic [PIXEL_W-1:0] mem_q [MAX_SOURCE_PIXELS];
  logic [PIXEL_W-1:0] rd0_q, rd1_q;
  logic [ADDR_W-1:0]  ra0, ra1;
  logic               mem_we;
  logic               issue_ab, issue_cd;
  logic               ab_vld_q, cd_vld_q, vert_vld_q;
  logic [CW-1:0]      credit_q, credit_d;
  logic [FRACTION_BITS-1:0] fx_q, fy_q, fyv_q;
  logic [HW-1:0]      top_q [NUM_CHAN];
  logic [HW-1:0]      bot_q [NUM_CHAN];
  logic [HW-1:0]      top_d [NUM_CHAN];
  logic [HW-1:0]      bot_d [NUM_CHAN];
  logic [HW:0]        acc_top, acc_bot;
  logic [VW-1:0]      acc_v;
  logic [WW-1:0]      wx0_head, wx1_head, wx0_b, wx1_b, wy0, wy1;

  // Loads write the store; a sample reads two neighbors a cycle, top pair then bottom.
  // A sample starts only when a result slot is reserved for it.
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    cmd_pop_o = 1'b0;
    issue_ab  = 1'b0;
    issue_cd  = 1'b0;
    ra0       = cmd_i.addr;
    ra1       = cmd_i.addr + 1'b1;
    case (state_q)
      ST_PAIR_AB: begin
        if (cmd_valid_i) begin
          if (!cmd_i.is_sample) begin
            mem_we    = 1'b1;
            cmd_pop_o = 1'b1;
          end else if (credit_q < CW'(RES_DEPTH)) begin
            issue_ab = 1'b1;
            state_d  = ST_PAIR_CD;
          end
        end
      end
      ST_PAIR_CD: begin
        ra0       = cmd_i.addr_c;
        ra1       = cmd_i.addr_c + 1'b1;
        issue_cd  = 1'b1;
        cmd_pop_o = 1'b1;
        state_d   = ST_PAIR_AB;
      end
      default: begin
        state_d = ST_PAIR_AB;
      end
    endcase
  end

  // Results in flight plus results waiting in the output queue.
  assign credit_d = credit_q + CW'(issue_ab) - CW'(res_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_PAIR_AB;
      credit_q   <= '0;
      ab_vld_q   <= 1'b0;
      cd_vld_q   <= 1'b0;
      vert_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      credit_q   <= credit_d;
      ab_vld_q   <= issue_ab;
      cd_vld_q   <= issue_cd;
      vert_vld_q <= cd_vld_q;
    end
  end

  // Image store: one write port shared with read port zero, two registered reads.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[ra0] <= cmd_i.pixel;
    end
  end

  always_ff @(posedge clk_i) begin
    rd0_q <= mem_q[ra0];
    rd1_q <= mem_q[ra1];
  end

  // Horizontal weights; the sample is still at the queue head while the top pair arrives.
  always_comb begin
    wx1_head = WW'(cmd_i.frac_x);
    wx0_head = ONE - wx1_head;
    wx1_b    = WW'(fx_q);
    wx0_b    = ONE - wx1_b;
    wy1      = WW'(fyv_q);
    wy0      = ONE - wy1;
  end

  // Horizontal blends of the top and bottom neighbor pairs per channel.
  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      acc_top = (HW+1)'(rd0_q[ch*CHAN_W +: CHAN_W]) * (HW+1)'(wx0_head)
              + (HW+1)'(rd1_q[ch*CHAN_W +: CHAN_W]) * (HW+1)'(wx1_head);
      acc_bot = (HW+1)'(rd0_q[ch*CHAN_W +: CHAN_W]) * (HW+1)'(wx0_b)
              + (HW+1)'(rd1_q[ch*CHAN_W +: CHAN_W]) * (HW+1)'(wx1_b);
      top_d[ch] = acc_top[HW-1:0];
      bot_d[ch] = acc_bot[HW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_cd) begin
      fx_q <= cmd_i.frac_x;
      fy_q <= cmd_i.frac_y;
    end
    if (ab_vld_q) begin
      top_q <= top_d;
    end
    if (cd_vld_q) begin
      bot_q <= bot_d;
      fyv_q <= fy_q;
    end
  end

  // Vertical blend and truncation to eight bits per channel.
  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      acc_v = VW'(top_q[ch]) * VW'(wy0) + VW'(bot_q[ch]) * VW'(wy1);
      res_pixel_o[ch*CHAN_W +: CHAN_W] = acc_v[2*FRACTION_BITS +: CHAN_W];
    end
  end

  assign res_push_o = vert_vld_q;

endmodule

@@ hw/rtl/bilinear_rgba8_resampler.sv @@
// Top level of the bilinear RGBA8 resampler: configuration, queues and the two ends.
//
// Load items write one 32-bit pixel into a 64K-entry image store; sample items return
// one pixel blended from the four source neighbors of the scaled destination position.
// The front end forms the store addresses and takes an item every cycle unless its held
// command meets a full command queue; that queue of CMD_DEPTH entries separates it from
// the back end. The back end writes a load directly and fetches a sample's neighbors as
// a top pair then a bottom pair, since the store has two read ports and a sample needs
// four neighbors, so no new sample starts before the last one's bottom pair. A result
// leaves through an output queue of RES_DEPTH entries. The store is not cleared by
// reset, and a sample must only touch entries that were loaded before it. Configuration
// must be written only while the block is idle; the block itself does not enforce it.
module bilinear_rgba8_resampler import blr_pkg::*; #(
  parameter int unsigned CMD_DEPTH = CMD_QUEUE_DEPTH,
  parameter int unsigned RES_DEPTH = RES_QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic [ADDR_W-1:0]    load_address_i,
  input  logic [PIXEL_W-1:0]   load_pixel_i,
  input  logic [DEST_W-1:0]    dest_column_i,
  input  logic [DEST_W-1:0]    dest_row_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIXEL_W-1:0]   out_pixel_o
);

  cfg_t               cfg_q;
  logic               cmd_push, cmd_push_ready;
  cmd_t               cmd_tail, cmd_head;
  logic [$bits(cmd_t)-1:0] cmd_head_vec;
  logic               cmd_head_vld, cmd_pop;
  logic               res_push, res_push_ready, res_pop;
  logic [PIXEL_W-1:0] res_pixel;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width <= SOURCE_WIDTH_RST;
      cfg_q.step_x       <= STEP_RST;
      cfg_q.step_y       <= STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SOURCE_WIDTH: cfg_q.source_width <= cfg_wdata_i[SRC_W-1:0];
        CFG_STEP_X:       cfg_q.step_x       <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_Y:       cfg_q.step_y       <= cfg_wdata_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end.
  blr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .load_address_i (load_address_i),
    .load_pixel_i   (load_pixel_i),
    .dest_column_i  (dest_column_i),
    .dest_row_i     (dest_row_i),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_tail),
    .cmd_ready_i    (cmd_push_ready)
  );

  // Command queue between the two ends.
  blr_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (cmd_push),
    .push_data_i  (cmd_tail),
    .push_ready_o (cmd_push_ready),
    .pop_i        (cmd_pop),
    .pop_valid_o  (cmd_head_vld),
    .pop_data_o   (cmd_head_vec)
  );

  assign cmd_head = cmd_t'(cmd_head_vec);

  // Back end.
  blr_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_head_vld),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_pop_i   (res_pop),
    .res_push_o  (res_push),
    .res_pixel_o (res_pixel)
  );

  // Output queue; its head is the result offered for transfer.
  blr_queue #(
    .WIDTH (PIXEL_W),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (res_push),
    .push_data_i  (res_pixel),
    .push_ready_o (res_push_ready),
    .pop_i        (res_pop),
    .pop_valid_o  (out_valid_o),
    .pop_data_o   (out_pixel_o)
  );

  assign res_pop = out_valid_o & out_ready_i;

`ifndef SYNTHESIS
  // The result slot reservation never lets a finished pixel meet a full output queue.
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> res_push_ready)
    else $error("result pushed into a full output queue");

  // The front end stalls input only when its held command cannot enter the queue.
  a_front_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (cmd_push && !cmd_push_ready))
    else $error("front end stalled without a blocked command");

  // Every result comes from a sample retired earlier by the fetch sequencer.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> $past(cmd_pop && cmd_head.is_sample, 2))
    else $error("result without a matching sample fetch");
`endif

endmodule

@@ tb/bilinear_rgba8_resampler_tb.sv @@
// Self-checking testbench for the bilinear RGBA8 resampler with a pixel scoreboard.
`timescale 1ns / 1ps

module bilinear_rgba8_resampler_tb;
  import blr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned ITEM_TARGET  = 950;
  localparam int unsigned RANDOM_PHASES = 8;

  // Mirrors the image store and register set, and predicts each blended pixel.
  class resampler_scoreboard;
    bit [PIXEL_W-1:0] image_mirror [MAX_SOURCE_PIXELS];
    bit               loaded_mask [MAX_SOURCE_PIXELS];
    bit [SRC_W-1:0]   source_width;
    bit [STEP_W-1:0]  step_x;
    bit [STEP_W-1:0]  step_y;
    bit [PIXEL_W-1:0] expected_pixels [$];
    int unsigned      loads;
    int unsigned      samples;
    int unsigned      checked;
    int unsigned      mismatches;

    function new();
      source_width = SOURCE_WIDTH_RST;
      step_x       = STEP_RST;
      step_y       = STEP_RST;
    endfunction

    function void write_register(cfg_idx_e idx, bit [CFG_W-1:0] value);
      case (idx)
        CFG_SOURCE_WIDTH: source_width = value[SRC_W-1:0];
        CFG_STEP_X:       step_x = value[STEP_W-1:0];
        CFG_STEP_Y:       step_y = value[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // Scale the destination position and find the four neighbor addresses.
    function void locate(input bit [DEST_W-1:0] col, input bit [DEST_W-1:0] row,
                         output bit [3:0][ADDR_W-1:0] nb,
                         output bit [FRACTION_BITS-1:0] fx,
                         output bit [FRACTION_BITS-1:0] fy);
      bit [63:0] px;
      bit [63:0] py;
      bit [63:0] base;
      px    = 64'(step_x) * 64'(col);
      py    = 64'(step_y) * 64'(row);
      base  = (py >> FRACTION_BITS) * 64'(source_width) + (px >> FRACTION_BITS);
      nb[0] = ADDR_W'(base);
      nb[1] = ADDR_W'(base + 64'd1);
      nb[2] = ADDR_W'(base + 64'(source_width));
      nb[3] = ADDR_W'(base + 64'(source_width) + 64'd1);
      fx    = px[FRACTION_BITS-1:0];
      fy    = py[FRACTION_BITS-1:0];
    endfunction

    // A load updates the mirror; a sample queues its blended pixel.
    function void note_item(opcode_e op, bit [ADDR_W-1:0] addr, bit [PIXEL_W-1:0] pixel,
                            bit [DEST_W-1:0] col, bit [DEST_W-1:0] row);
      bit [3:0][ADDR_W-1:0]    nb;
      bit [FRACTION_BITS-1:0]  fx;
      bit [FRACTION_BITS-1:0]  fy;
      bit [63:0]               one;
      bit [63:0]               weight [4];
      bit [63:0]               sum;
      bit [PIXEL_W-1:0]        blended;
      int                      c;
      int                      n;
      if (op == OP_LOAD) begin
        image_mirror[addr] = pixel;
        loaded_mask[addr]  = 1'b1;
        loads++;
        return;
      end
      locate(col, row, nb, fx, fy);
      one       = 64'd1 << FRACTION_BITS;
      weight[0] = (one - 64'(fx)) * (one - 64'(fy));
      weight[1] = 64'(fx) * (one - 64'(fy));
      weight[2] = (one - 64'(fx)) * 64'(fy);
      weight[3] = 64'(fx) * 64'(fy);
      for (c = 0; c < NUM_CHAN; c++) begin
        sum = 64'd0;
        for (n = 0; n < 4; n++) begin
          sum += 64'(image_mirror[nb[n]][c*CHAN_W +: CHAN_W]) * weight[n];
        end
        blended[c*CHAN_W +: CHAN_W] = sum[2*FRACTION_BITS +: CHAN_W];
      end
      expected_pixels.push_back(blended);
      samples++;
    endfunction

    function void check_pixel(logic [PIXEL_W-1:0] got);
      bit [PIXEL_W-1:0] want;
      checked++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Output pixel %08h arrived with no sample pending", got);
        end
        return;
      end
      want = expected_pixels.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Output pixel %0d: expected %08h, got %08h", checked, want, got);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 opcode_i;
  logic [ADDR_W-1:0]    load_address_i;
  logic [PIXEL_W-1:0]   load_pixel_i;
  logic [DEST_W-1:0]    dest_column_i;
  logic [DEST_W-1:0]    dest_row_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [PIXEL_W-1:0]   out_pixel_o;

  resampler_scoreboard board;
  int unsigned         cycle_count;
  int unsigned         items_sent;
  int unsigned         settings_used;
  bit                  tx_steady;
  bit                  rx_steady;

  bilinear_rgba8_resampler uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .load_address_i (load_address_i),
    .load_pixel_i   (load_pixel_i),
    .dest_column_i  (dest_column_i),
    .dest_row_i     (dest_row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_pixel_o    (out_pixel_o)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Every output transfer is checked against the oldest predicted pixel.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_pixel(out_pixel_o);
    end
  end

  // Mostly short idle stretches, occasionally a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pixels with saturated or empty channels show up often to hit the channel extremes.
  function automatic bit [PIXEL_W-1:0] random_pixel();
    bit [PIXEL_W-1:0] p;
    int               c;
    p = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      for (c = 0; c < NUM_CHAN; c++) begin
        p[c*CHAN_W +: CHAN_W] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
    end
    return p;
  endfunction

  function automatic bit [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return STEP_RST;
      2:       return '1;
      3:       return STEP_W'($urandom);
      4, 5, 6: return STEP_W'($urandom_range(32'h1000, 32'h10000));
      default: return STEP_W'($urandom_range(0, 32'h3ffff));
    endcase
  endfunction

  // Output side: ready in random bursts with stalls between them.
  initial begin : receiver
    int unsigned run;
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 24);
      @(negedge clk_i);
      out_ready_i = 1'b1;
      repeat (run - 1) @(negedge clk_i);
      stall = rx_steady ? 0 : idle_length();
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  // Present one item, hold it until it transfers, then idle for a random gap that may be zero.
  task automatic send_item(opcode_e op, bit [ADDR_W-1:0] addr, bit [PIXEL_W-1:0] pixel,
                           bit [DEST_W-1:0] col, bit [DEST_W-1:0] row);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i     = 1'b1;
    opcode_i       = op;
    load_address_i = addr;
    load_pixel_i   = pixel;
    dest_column_i  = col;
    dest_row_i     = row;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(op, addr, pixel, col, row);
    items_sent++;
    gap = tx_steady ? 0 : idle_length();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Load any neighbor that holds no pixel yet, then request the sample.
  task automatic sample_at(bit [DEST_W-1:0] col, bit [DEST_W-1:0] row);
    bit [3:0][ADDR_W-1:0]   nb;
    bit [FRACTION_BITS-1:0] fx;
    bit [FRACTION_BITS-1:0] fy;
    int                     n;
    board.locate(col, row, nb, fx, fy);
    for (n = 0; n < 4; n++) begin
      if (!board.loaded_mask[nb[n]]) begin
        send_item(OP_LOAD, nb[n], random_pixel(), DEST_W'($urandom), DEST_W'($urandom));
      end
    end
    send_item(OP_SAMPLE, ADDR_W'($urandom), PIXEL_W'($urandom), col, row);
  endtask

  // Stop sending and let every pending result come out.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_register(cfg_idx_e idx, bit [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    board.write_register(idx, value);
  endtask

  // New geometry once the block is idle; the width write carries junk above bit 8.
  task automatic set_geometry(bit [SRC_W-1:0] width, bit [STEP_W-1:0] sx,
                              bit [STEP_W-1:0] sy);
    bit [CFG_W-1:0] width_word;
    wait_for_results();
    width_word = CFG_W'($urandom);
    width_word[SRC_W-1:0] = width;
    program_register(CFG_SOURCE_WIDTH, width_word);
    program_register(CFG_STEP_X, CFG_W'(sx));
    program_register(CFG_STEP_Y, CFG_W'(sy));
    settings_used++;
  endtask

  // Main stimulus.
  initial begin : stimulus
    int unsigned      phase;
    int unsigned      phase_end;
    bit [SRC_W-1:0]   width;
    bit [DEST_W-1:0]  span;
    board          = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_SOURCE_WIDTH;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_LOAD;
    load_address_i = '0;
    load_pixel_i   = '0;
    dest_column_i  = '0;
    dest_row_i     = '0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    settings_used  = 1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset geometry: extreme addresses and pixels, wrapping reads.
    send_item(OP_LOAD, '1, '1, '0, '0);
    send_item(OP_LOAD, '0, '0, '1, '1);
    sample_at('0, '0);
    sample_at('1, '1);
    // Half steps on a two-pixel-wide image give real fractions.
    set_geometry(SRC_W'(2), STEP_W'(32'h8000), STEP_W'(32'h8000));
    sample_at(DEST_W'(1), DEST_W'(1));
    sample_at(DEST_W'(3), DEST_W'(2));
    // Zero steps put the top-left neighbor on entry zero.
    set_geometry('0, '0, '0);
    sample_at('1, DEST_W'(517));
    // Width one with the largest steps wraps far around the store.
    set_geometry(SRC_W'(1), '1, '1);
    sample_at('1, '1);
    // Widest register value.
    set_geometry('1, STEP_W'(32'h18000), STEP_W'(32'h10000));
    sample_at('1, '0);
    sample_at('0, '1);

    // Random phases, each under its own geometry.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 7))
        0:       width = SRC_W'(2);
        1:       width = SRC_W'(256);
        2:       width = '1;
        3:       width = SRC_W'($urandom_range(0, 511));
        default: width = SRC_W'($urandom_range(2, 256));
      endcase
      set_geometry(width, pick_step(), pick_step());
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      span      = $urandom_range(0, 1) ? DEST_W'(31) : '1;
      phase_end = items_sent + (ITEM_TARGET - items_sent) / (RANDOM_PHASES - phase);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) begin
          // Stray loads, anywhere in the store.
          send_item(OP_LOAD, ADDR_W'($urandom), random_pixel(),
                    DEST_W'($urandom), DEST_W'($urandom));
        end else if ($urandom_range(0, 4) == 0) begin
          sample_at(DEST_W'($urandom), DEST_W'($urandom));
        end else begin
          sample_at(DEST_W'($urandom_range(0, span)), DEST_W'($urandom_range(0, span)));
        end
        // Now and then, and in phase zero if the count hits its mark, wait until the block empties.
        if ((phase == 0 && items_sent == phase_end - 40) || $urandom_range(0, 199) == 0) begin
          wait_for_results();
        end
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    wait_for_results();
    $display("Sent %0d items (%0d loads, %0d samples) under %0d register settings.",
             items_sent, board.loads, board.samples, settings_used);
    $display("Checked %0d output pixels with %0d mismatches.", board.checked,
             board.mismatches);
    if (board.mismatches == 0 && board.expected_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      if (board.expected_pixels.size() != 0) begin
        $display("%0d expected output pixels never arrived", board.expected_pixels.size());
      end
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ bilinear_rgba8_resampler.f @@
hw/rtl/blr_pkg.sv
hw/rtl/blr_queue.sv
hw/rtl/blr_front.sv
hw/rtl/blr_back.sv
hw/rtl/bilinear_rgba8_resampler.sv
tb/bilinear_rgba8_resampler_tb.sv
